[design/psi_pkg.sv]
// Shared constants, types and helper functions for the pad source index block.
`default_nettype none

package psi_pkg;

  localparam int unsigned MAX_CHANNELS = 1024;
  localparam int unsigned MAX_FRAMES   = 256;
  localparam int unsigned MAX_SIDE     = 1024;
  localparam int unsigned MAX_PAD      = 16;

  // Field widths of the stream words
  localparam int unsigned CHAN_W  = 10;
  localparam int unsigned FRAME_W = 9;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned IDX_W   = 38;

  // Register widths
  localparam int unsigned NC_W   = 11;
  localparam int unsigned NF_W   = 9;
  localparam int unsigned SIDE_W = 11;
  localparam int unsigned PAD_W  = 5;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned IN_TDATA_W  = ((CHAN_W + FRAME_W + 2 * POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned USER_ZERO   = 0;
  localparam int unsigned USER_ERR    = 1;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Internal widths
  localparam int unsigned TOT_W  = NF_W + 1;
  localparam int unsigned EXT_W  = SIDE_W + 1;
  localparam int unsigned PER_W  = SIDE_W + 1;
  // Quotient bits of the reflect fold: worst case is a two-sample side
  localparam int unsigned QBITS  = $clog2((MAX_PAD + 1) / 2 + 1);
  localparam int unsigned DIV_W  = PER_W + QBITS - 1;
  localparam int unsigned SRC_W  = SIDE_W - 1;
  localparam int unsigned T1_W   = CHAN_W + NF_W;
  localparam int unsigned T2_W   = T1_W + SIDE_W;
  localparam int unsigned PROD_W = T2_W + SIDE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZEROS     = 2'd0,
    MODE_REFLECT   = 2'd1,
    MODE_REPLICATE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_NUM_CHANNELS = 3'd0,
    REG_NUM_FRAMES   = 3'd1,
    REG_SRC_HEIGHT   = 3'd2,
    REG_SRC_WIDTH    = 3'd3,
    REG_PAD_FRONT    = 3'd4,
    REG_PAD_BACK     = 3'd5,
    REG_PAD_SIDE     = 3'd6,
    REG_PAD_MODE     = 3'd7
  } reg_idx_e;

  // Effective (saturated) configuration
  typedef struct packed {
    logic [NC_W-1:0]   nc;
    logic [NF_W-1:0]   nf;
    logic [SIDE_W-1:0] h;
    logic [SIDE_W-1:0] w;
    logic [PAD_W-1:0]  pf;
    logic [PAD_W-1:0]  pb;
    logic [PAD_W-1:0]  ps;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  // One spatial axis before folding
  typedef struct packed {
    logic [POS_W-1:0] a;     // |pos - pad|, reduced in place during the fold
    logic             lo;    // position lies before the first sample
    logic             inr;   // position maps straight onto the source
  } ax_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [NF_W-1:0]   sf;
    logic              err;
    ax_t               row;
    ax_t               col;
  } s1_t;

  typedef struct packed {
    logic [T1_W-1:0] t1;
    logic            err;
    ax_t             row;
    ax_t             col;
  } s2_t;

  typedef struct packed {
    logic [T1_W-1:0]  t1;
    logic             err;
    logic             zero;
    logic [SRC_W-1:0] sr;
    logic [SRC_W-1:0] sc;
  } s3_t;

  typedef struct packed {
    logic [T2_W-1:0]  t2;
    logic             err;
    logic             zero;
    logic [SRC_W-1:0] sc;
  } s4_t;

  typedef struct packed {
    logic [SRC_W-1:0] val;
    logic             zero;
  } map_t;

  function automatic ax_t axis_pre(input logic [POS_W-1:0] pos,
                                   input logic [PAD_W-1:0] pad,
                                   input logic [SIDE_W-1:0] size);
    ax_t              ax;
    logic [POS_W-1:0] p_ext;
    p_ext  = POS_W'(pad);
    ax.lo  = pos < p_ext;
    ax.a   = ax.lo ? (p_ext - pos) : (pos - p_ext);
    ax.inr = !ax.lo && (SIDE_W'(ax.a) < size);
    return ax;
  endfunction

  function automatic logic [PER_W-1:0] period_of(input logic [SIDE_W-1:0] size);
    logic [PER_W-1:0] p;
    p = PER_W'(size - SIDE_W'(1)) << 1;
    return p;
  endfunction

  // One restoring step of the remainder
  function automatic logic [POS_W-1:0] div_step(input logic [POS_W-1:0] r,
                                                input logic [DIV_W-1:0] d);
    logic [POS_W-1:0] res;
    res = (DIV_W'(r) >= d) ? (r - POS_W'(d)) : r;
    return res;
  endfunction

  function automatic map_t axis_map(input ax_t ax,
                                    input logic [SIDE_W-1:0] size,
                                    input logic [MODE_W-1:0] mode);
    map_t             m;
    logic [PER_W-1:0] per;
    per    = period_of(size);
    m.val  = '0;
    m.zero = 1'b0;
    if (ax.inr) begin
      m.val = SRC_W'(ax.a);
    end else begin
      case (mode)
        MODE_REFLECT: begin
          if (size == SIDE_W'(1)) begin
            m.val = '0;
          end else if (SIDE_W'(ax.a) >= size) begin
            m.val = SRC_W'(per - PER_W'(ax.a));
          end else begin
            m.val = SRC_W'(ax.a);
          end
        end
        MODE_REPLICATE: begin
          m.val = ax.lo ? '0 : SRC_W'(size - SIDE_W'(1));
        end
        default: begin
          m.zero = 1'b1;
        end
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[design/psi_front.sv]
// Stage one: range check, frame clamp and axis offsets.
`default_nettype none

module psi_front
  import psi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_vld_i,
  output logic               in_rdy_o,
  input  logic [CHAN_W-1:0]  chan_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [POS_W-1:0]   row_i,
  input  logic [POS_W-1:0]   col_i,
  output logic               out_vld_o,
  input  logic               out_rdy_i,
  output s1_t                out_o
);

  logic             vld_q;
  s1_t              s1_d, s1_q;
  logic [TOT_W-1:0] tot;
  logic [EXT_W-1:0] ext_h, ext_w;
  logic [NF_W-1:0]  fr_off;

  assign in_rdy_o = !vld_q || out_rdy_i;

  always_comb begin
    tot    = TOT_W'(cfg_i.nf) + TOT_W'(cfg_i.pf) + TOT_W'(cfg_i.pb);
    ext_h  = EXT_W'(cfg_i.h) + (EXT_W'(cfg_i.ps) << 1);
    ext_w  = EXT_W'(cfg_i.w) + (EXT_W'(cfg_i.ps) << 1);
    fr_off = NF_W'(frame_i) - NF_W'(cfg_i.pf);

    s1_d.chan = chan_i;
    s1_d.err  = (NC_W'(chan_i) >= cfg_i.nc) || (TOT_W'(frame_i) >= tot) ||
                (EXT_W'(row_i) >= ext_h) || (EXT_W'(col_i) >= ext_w);

    // Frames always replicate the edge frame
    if (NF_W'(frame_i) < NF_W'(cfg_i.pf)) begin
      s1_d.sf = '0;
    end else if (fr_off >= cfg_i.nf) begin
      s1_d.sf = cfg_i.nf - NF_W'(1);
    end else begin
      s1_d.sf = fr_off;
    end

    s1_d.row = axis_pre(row_i, cfg_i.ps, cfg_i.h);
    s1_d.col = axis_pre(col_i, cfg_i.ps, cfg_i.w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      s1_q <= s1_d;
    end
  end

  assign out_vld_o = vld_q;
  assign out_o     = s1_q;

endmodule

`default_nettype wire

[design/psi_fold.sv]
// Stages two and three: reflect remainder, axis mapping and channel-frame product.
`default_nettype none

module psi_fold
  import psi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_vld_i,
  output logic in_rdy_o,
  input  s1_t  in_i,
  output logic out_vld_o,
  input  logic out_rdy_i,
  output s3_t  out_o
);

  logic             s2_vld_q, s3_vld_q;
  logic             rdy2, rdy3;
  s2_t              s2_d, s2_q;
  s3_t              s3_d, s3_q;
  logic [PER_W-1:0] per_h, per_w;
  map_t             mr, mc;

  assign rdy3     = !s3_vld_q || out_rdy_i;
  assign rdy2     = !s2_vld_q || rdy3;
  assign in_rdy_o = rdy2;

  assign per_h = period_of(cfg_i.h);
  assign per_w = period_of(cfg_i.w);

  // Upper quotient bits of the remainder, plus the channel-frame term
  always_comb begin
    s2_d.t1  = T1_W'(in_i.chan) * T1_W'(cfg_i.nf) + T1_W'(in_i.sf);
    s2_d.err = in_i.err;
    s2_d.row = in_i.row;
    s2_d.col = in_i.col;
    for (int k = QBITS - 1; k >= QBITS / 2; k--) begin
      if (!in_i.row.inr) begin
        s2_d.row.a = div_step(s2_d.row.a, DIV_W'(per_h) << k);
      end
      if (!in_i.col.inr) begin
        s2_d.col.a = div_step(s2_d.col.a, DIV_W'(per_w) << k);
      end
    end
  end

  // Lower quotient bits, then fold and pick the source position
  always_comb begin
    s3_d.t1  = s2_q.t1;
    s3_d.err = s2_q.err;
    mr       = '0;
    mc       = '0;
    begin : lower_steps
      ax_t rx, cx;
      rx = s2_q.row;
      cx = s2_q.col;
      for (int k = QBITS / 2 - 1; k >= 0; k--) begin
        if (!rx.inr) begin
          rx.a = div_step(rx.a, DIV_W'(per_h) << k);
        end
        if (!cx.inr) begin
          cx.a = div_step(cx.a, DIV_W'(per_w) << k);
        end
      end
      mr = axis_map(rx, cfg_i.h, cfg_i.mode);
      mc = axis_map(cx, cfg_i.w, cfg_i.mode);
    end
    s3_d.zero = s2_q.err || mr.zero || mc.zero;
    s3_d.sr   = mr.val;
    s3_d.sc   = mc.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_vld_q <= in_vld_i;
      end
      if (rdy3) begin
        s3_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_vld_i) begin
      s2_q <= s2_d;
    end
    if (rdy3 && s2_vld_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_vld_o = s3_vld_q;
  assign out_o     = s3_q;

endmodule

`default_nettype wire

[design/psi_index.sv]
// Stages four and five: row and column products forming the linear index.
`default_nettype none

module psi_index
  import psi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_vld_i,
  output logic             in_rdy_o,
  input  s3_t              in_i,
  output logic             out_vld_o,
  input  logic             out_rdy_i,
  output logic [IDX_W-1:0] index_o,
  output logic             zero_o,
  output logic             err_o
);

  logic              s4_vld_q, s5_vld_q;
  logic              rdy4, rdy5;
  s4_t               s4_d, s4_q;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  index_d, index_q;
  logic              zero_q, err_q;

  assign rdy5     = !s5_vld_q || out_rdy_i;
  assign rdy4     = !s4_vld_q || rdy5;
  assign in_rdy_o = rdy4;

  always_comb begin
    s4_d.t2   = T2_W'(in_i.t1) * T2_W'(cfg_i.h) + T2_W'(in_i.sr);
    s4_d.err  = in_i.err;
    s4_d.zero = in_i.zero;
    s4_d.sc   = in_i.sc;
  end

  // Zero-filled words carry index zero
  always_comb begin
    prod    = PROD_W'(s4_q.t2) * PROD_W'(cfg_i.w) + PROD_W'(s4_q.sc);
    index_d = s4_q.zero ? '0 : prod[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (rdy4) begin
        s4_vld_q <= in_vld_i;
      end
      if (rdy5) begin
        s5_vld_q <= s4_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_vld_i) begin
      s4_q <= s4_d;
    end
    if (rdy5 && s4_vld_q) begin
      index_q <= index_d;
      zero_q  <= s4_q.zero;
      err_q   <= s4_q.err;
    end
  end

  assign out_vld_o = s5_vld_q;
  assign index_o   = index_q;
  assign zero_o    = zero_q;
  assign err_o     = err_q;

endmodule

`default_nettype wire

[design/pad_source_index.sv]
// Throughput: one word per cycle while the output is not stalled; five register stages
// (offsets, two remainder stages, two multiply stages) each hold one word and empty
// stages close up under a stall.
// Reset (rst_ni low, asynchronous): all stage valid bits clear, sizes return to 1,
// pads and mode to 0; the block is ready on the first cycle after reset.
`default_nettype none

module pad_source_index
  import psi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // Coordinate input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // chan, out_frame, out_row, out_col, zero pad
  // Result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // source_index, zero pad
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // zero_fill, range_error
);

  logic [NC_W-1:0]   num_channels_q;
  logic [NF_W-1:0]   num_frames_q;
  logic [SIDE_W-1:0] src_height_q, src_width_q;
  logic [PAD_W-1:0]  pad_front_q, pad_back_q, pad_side_q;
  logic [MODE_W-1:0] pad_mode_q;

  reg_idx_e          reg_idx;
  logic              wr_en;
  cfg_t              cfg;

  logic              f_vld, f_rdy, x_vld, x_rdy;
  s1_t               f_data;
  s3_t               x_data;
  logic [IDX_W-1:0]  index;
  logic              zero, err;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= NC_W'(1);
      num_frames_q   <= NF_W'(1);
      src_height_q   <= SIDE_W'(1);
      src_width_q    <= SIDE_W'(1);
      pad_front_q    <= '0;
      pad_back_q     <= '0;
      pad_side_q     <= '0;
      pad_mode_q     <= MODE_ZEROS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_CHANNELS: num_channels_q <= pwdata[NC_W-1:0];
        REG_NUM_FRAMES:   num_frames_q   <= pwdata[NF_W-1:0];
        REG_SRC_HEIGHT:   src_height_q   <= pwdata[SIDE_W-1:0];
        REG_SRC_WIDTH:    src_width_q    <= pwdata[SIDE_W-1:0];
        REG_PAD_FRONT:    pad_front_q    <= pwdata[PAD_W-1:0];
        REG_PAD_BACK:     pad_back_q     <= pwdata[PAD_W-1:0];
        REG_PAD_SIDE:     pad_side_q     <= pwdata[PAD_W-1:0];
        REG_PAD_MODE:     pad_mode_q     <= pwdata[MODE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_CHANNELS: prdata = APB_DW'(num_channels_q);
      REG_NUM_FRAMES:   prdata = APB_DW'(num_frames_q);
      REG_SRC_HEIGHT:   prdata = APB_DW'(src_height_q);
      REG_SRC_WIDTH:    prdata = APB_DW'(src_width_q);
      REG_PAD_FRONT:    prdata = APB_DW'(pad_front_q);
      REG_PAD_BACK:     prdata = APB_DW'(pad_back_q);
      REG_PAD_SIDE:     prdata = APB_DW'(pad_side_q);
      REG_PAD_MODE:     prdata = APB_DW'(pad_mode_q);
      default:          prdata = '0;
    endcase
  end

  // Size zero acts as one; sizes and pads saturate at their limits
  always_comb begin
    cfg.nc = (num_channels_q == '0) ? NC_W'(1) :
             (32'(num_channels_q) > MAX_CHANNELS) ? NC_W'(MAX_CHANNELS) : num_channels_q;
    cfg.nf = (num_frames_q == '0) ? NF_W'(1) :
             (32'(num_frames_q) > MAX_FRAMES) ? NF_W'(MAX_FRAMES) : num_frames_q;
    cfg.h  = (src_height_q == '0) ? SIDE_W'(1) :
             (32'(src_height_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : src_height_q;
    cfg.w  = (src_width_q == '0) ? SIDE_W'(1) :
             (32'(src_width_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : src_width_q;
    cfg.pf = (32'(pad_front_q) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_front_q;
    cfg.pb = (32'(pad_back_q) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_back_q;
    cfg.ps = (32'(pad_side_q) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_side_q;
    cfg.mode = pad_mode_q;
  end

  psi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .chan_i    (s_axis_tdata[CHAN_W-1:0]),
    .frame_i   (s_axis_tdata[CHAN_W +: FRAME_W]),
    .row_i     (s_axis_tdata[CHAN_W + FRAME_W +: POS_W]),
    .col_i     (s_axis_tdata[CHAN_W + FRAME_W + POS_W +: POS_W]),
    .out_vld_o (f_vld),
    .out_rdy_i (f_rdy),
    .out_o     (f_data)
  );

  psi_fold u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_vld_i  (f_vld),
    .in_rdy_o  (f_rdy),
    .in_i      (f_data),
    .out_vld_o (x_vld),
    .out_rdy_i (x_rdy),
    .out_o     (x_data)
  );

  psi_index u_index (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_vld_i  (x_vld),
    .in_rdy_o  (x_rdy),
    .in_i      (x_data),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .index_o   (index),
    .zero_o    (zero),
    .err_o     (err)
  );

  assign m_axis_tdata           = OUT_TDATA_W'(index);
  assign m_axis_tuser[USER_ZERO] = zero;
  assign m_axis_tuser[USER_ERR]  = err;

endmodule

`default_nettype wire

[design/psi_checker.sv]
// Port-level checks of the pad source index block, bound to its top level.
`default_nettype none

module psi_checker
  import psi_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // An out-of-extent coordinate is always zero filled
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_ERR] |-> m_axis_tuser[USER_ZERO])
    else $error("range error without zero fill");

  // Zero-filled words carry index zero
  a_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_ZERO] |-> m_axis_tdata == '0)
    else $error("zero fill with nonzero index");

  // Padding bits above the index stay clear
  a_pad_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:IDX_W] == '0)
    else $error("nonzero padding bits in output word");

  // Hold a stalled output word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind pad_source_index psi_checker u_psi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the pad source index block: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_top
  import psi_pkg::*;
;

  localparam int unsigned PIPE_LAT = 5;
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 105;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [FRAME_W-1:0] frame;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
  } coord_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             zero_fill;
    logic             range_err;
  } result_t;

  typedef struct {
    int unsigned nc, nf, h, w, pf, pb, ps;
    logic [MODE_W-1:0] mode;
  } eff_cfg_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // chan, out_frame, out_row, out_col, zero pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // source_index, zero pad
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // zero_fill, range_error

  pad_source_index dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Register shadow, raw values as written
  logic [NC_W-1:0]   nc_r = 1;
  logic [NF_W-1:0]   nf_r = 1;
  logic [SIDE_W-1:0] h_r = 1;
  logic [SIDE_W-1:0] w_r = 1;
  logic [PAD_W-1:0]  pf_r = 0;
  logic [PAD_W-1:0]  pb_r = 0;
  logic [PAD_W-1:0]  ps_r = 0;
  logic [MODE_W-1:0] mode_r = MODE_ZEROS;

  coord_t  pending_q[$];
  result_t expected_q[$];
  coord_t  cur_coord;
  bit      in_fire = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_zero = 0;
  int unsigned n_range = 0;
  int unsigned n_settings = 0;
  bit hold_tgl = 1'b0;
  bit hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned stall_pct = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (n_errors < 40)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic int unsigned sat_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned sat_pad(int unsigned v);
    return (v > MAX_PAD) ? MAX_PAD : v;
  endfunction

  function automatic eff_cfg_t eff_cfg();
    eff_cfg_t e;
    e.nc   = sat_size(nc_r, MAX_CHANNELS);
    e.nf   = sat_size(nf_r, MAX_FRAMES);
    e.h    = sat_size(h_r, MAX_SIDE);
    e.w    = sat_size(w_r, MAX_SIDE);
    e.pf   = sat_pad(pf_r);
    e.pb   = sat_pad(pb_r);
    e.ps   = sat_pad(ps_r);
    e.mode = mode_r;
    return e;
  endfunction

  // Map a padded row or column onto the source side; flag zero fill
  function automatic int unsigned fold_axis(int unsigned pos, int unsigned pad,
                                            int unsigned size, logic [MODE_W-1:0] mode,
                                            output bit zero);
    int          off;
    int unsigned a, per, r;
    zero = 1'b0;
    off = int'(pos) - int'(pad);
    if (off >= 0 && off < int'(size)) return off;
    if (mode == MODE_REFLECT) begin
      if (size == 1) return 0;
      per = 2 * (size - 1);
      a = (off < 0) ? -off : off;
      r = a % per;
      if (r >= size) r = per - r;
      return r;
    end
    if (mode == MODE_REPLICATE) return (off < 0) ? 0 : size - 1;
    zero = 1'b1;
    return 0;
  endfunction

  function automatic result_t predict_source(coord_t c);
    eff_cfg_t    e;
    result_t     r;
    int unsigned sf, sr, sc;
    bit          zr, zc;
    longint unsigned lin;
    e = eff_cfg();
    r = '0;
    if (c.chan >= e.nc || c.frame >= e.nf + e.pf + e.pb ||
        c.row >= e.h + 2 * e.ps || c.col >= e.w + 2 * e.ps) begin
      r.zero_fill = 1'b1;
      r.range_err = 1'b1;
      return r;
    end
    // Frames always clamp to the edge frame
    if (c.frame < e.pf) sf = 0;
    else if (c.frame - e.pf >= e.nf) sf = e.nf - 1;
    else sf = c.frame - e.pf;
    sr = fold_axis(c.row, e.ps, e.h, e.mode, zr);
    sc = fold_axis(c.col, e.ps, e.w, e.mode, zc);
    if (zr || zc) begin
      r.zero_fill = 1'b1;
    end else begin
      lin = ((longint'(c.chan) * e.nf + sf) * e.h + sr) * e.w + sc;
      r.index = lin[IDX_W-1:0];
    end
    return r;
  endfunction

  // Driver: bursts of words with random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (in_fire || !s_axis_tvalid) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_coord = pending_q.pop_front();
        s_axis_tdata <= IN_TDATA_W'({cur_coord.col, cur_coord.row, cur_coord.frame,
                                     cur_coord.chan});
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: segments of varying stall density, plus a long hold on request
  always @(negedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      seg_left--;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t got, want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      expected_q.push_back(predict_source(cur_coord));
      n_items++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.index     = m_axis_tdata[IDX_W-1:0];
      got.zero_fill = m_axis_tuser[USER_ZERO];
      got.range_err = m_axis_tuser[USER_ERR];
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected", 64'(got.index), 0);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (want.zero_fill) n_zero++;
        if (want.range_err) n_range++;
        if (got.index != want.index)
          report_mismatch("source_index", 64'(got.index), 64'(want.index));
        if (got.zero_fill != want.zero_fill)
          report_mismatch("zero_fill", 64'(got.zero_fill), 64'(want.zero_fill));
        if (got.range_err != want.range_err)
          report_mismatch("range_error", 64'(got.range_err), 64'(want.range_err));
      end
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_NUM_CHANNELS: nc_r   = val[NC_W-1:0];
      REG_NUM_FRAMES:   nf_r   = val[NF_W-1:0];
      REG_SRC_HEIGHT:   h_r    = val[SIDE_W-1:0];
      REG_SRC_WIDTH:    w_r    = val[SIDE_W-1:0];
      REG_PAD_FRONT:    pf_r   = val[PAD_W-1:0];
      REG_PAD_BACK:     pb_r   = val[PAD_W-1:0];
      REG_PAD_SIDE:     ps_r   = val[PAD_W-1:0];
      default:          mode_r = val[MODE_W-1:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int unsigned nc, int unsigned nf, int unsigned h, int unsigned w,
                            int unsigned pf, int unsigned pb, int unsigned ps,
                            logic [MODE_W-1:0] mode);
    cfg_write(REG_NUM_CHANNELS, nc);
    cfg_write(REG_NUM_FRAMES, nf);
    cfg_write(REG_SRC_HEIGHT, h);
    cfg_write(REG_SRC_WIDTH, w);
    cfg_write(REG_PAD_FRONT, pf);
    cfg_write(REG_PAD_BACK, pb);
    cfg_write(REG_PAD_SIDE, ps);
    cfg_write(REG_PAD_MODE, APB_DW'(mode));
    n_settings++;
  endtask

  // Hold until every word is out and the pipeline has emptied
  task automatic drain();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_LAT + 3) @(posedge clk_i);
  endtask

  task automatic send(int unsigned ch, int unsigned fr, int unsigned row, int unsigned col);
    coord_t c;
    c.chan  = CHAN_W'(ch);
    c.frame = FRAME_W'(fr);
    c.row   = POS_W'(row);
    c.col   = POS_W'(col);
    pending_q.push_back(c);
  endtask

  function automatic int unsigned rnd_size(int unsigned maxv, int unsigned width);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(maxv + 1, (1 << width) - 1);
      2, 3, 4: return $urandom_range(1, 4);
      default: return $urandom_range(1, maxv);
    endcase
  endfunction

  function automatic int unsigned rnd_pad();
    if ($urandom_range(0, 7) == 0) return $urandom_range(MAX_PAD + 1, (1 << PAD_W) - 1);
    return $urandom_range(0, MAX_PAD);
  endfunction

  // Position inside the extent, biased toward both borders
  function automatic int unsigned pick_pos(int unsigned ext, int unsigned pad);
    int unsigned span;
    span = (pad + 3 < ext) ? pad + 3 : ext;
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, span - 1);
      1:       return ext - 1 - $urandom_range(0, span - 1);
      default: return $urandom_range(0, ext - 1);
    endcase
  endfunction

  function automatic coord_t gen_coord();
    eff_cfg_t    e;
    coord_t      c;
    int unsigned sel, fext, rext, cext;
    e = eff_cfg();
    fext = e.nf + e.pf + e.pb;
    rext = e.h + 2 * e.ps;
    cext = e.w + 2 * e.ps;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      c = coord_t'({$urandom, $urandom});
      return c;
    end
    c.chan  = CHAN_W'($urandom_range(0, e.nc - 1));
    c.frame = FRAME_W'(pick_pos(fext, e.pf + e.pb));
    c.row   = POS_W'(pick_pos(rext, e.ps));
    c.col   = POS_W'(pick_pos(cext, e.ps));
    // Push a single field just past its extent
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0: if (e.nc < MAX_CHANNELS) c.chan = CHAN_W'($urandom_range(e.nc, e.nc + 3));
        1: c.frame = FRAME_W'(fext + $urandom_range(0, 3));
        2: c.row = POS_W'(rext + $urandom_range(0, 3));
        default: c.col = POS_W'(cext + $urandom_range(0, 3));
      endcase
    end
    return c;
  endfunction

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: a single source element
    send(0, 0, 0, 0);
    send(1023, 511, 2047, 2047);
    drain();

    // Small volume, reflect: corners, pads, each field out of range
    set_config(3, 2, 4, 5, 2, 1, 3, MODE_REFLECT);
    send(0, 0, 0, 0);
    send(2, 4, 9, 10);
    send(1, 2, 3, 3);
    send(0, 3, 1, 8);
    send(3, 0, 3, 3);
    send(0, 5, 3, 3);
    send(0, 2, 10, 3);
    send(0, 2, 3, 11);
    drain();
    cfg_write(REG_PAD_MODE, APB_DW'(MODE_REPLICATE));
    send(0, 0, 0, 0);
    send(2, 4, 9, 10);
    send(1, 3, 2, 7);
    drain();
    cfg_write(REG_PAD_MODE, APB_DW'(MODE_ZEROS));
    send(0, 2, 0, 3);
    send(1, 2, 3, 3);
    drain();
    cfg_write(REG_PAD_MODE, APB_DW'(MODE_UNDEF));
    send(0, 2, 3, 0);
    send(1, 2, 4, 4);
    drain();
    // Single-sample sides under reflect fold to zero
    set_config(3, 2, 1, 1, 2, 1, 3, MODE_REFLECT);
    send(0, 1, 0, 6);
    send(0, 2, 3, 3);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(1, 1, 1, 1, 16, 0, 16, MODE_REFLECT);
        1: set_config(MAX_CHANNELS, MAX_FRAMES, MAX_SIDE, MAX_SIDE, 16, 16, 16,
                      MODE_REPLICATE);
        2: set_config(2047, 511, 2047, 2047, 31, 31, 31, MODE_REFLECT);
        3: set_config(0, 0, 0, 0, 5, 7, 9, MODE_ZEROS);
        4: set_config(7, 5, 2, 3, 3, 2, 16, MODE_REFLECT);
        5: set_config(rnd_size(MAX_CHANNELS, NC_W), rnd_size(MAX_FRAMES, NF_W),
                      rnd_size(MAX_SIDE, SIDE_W), rnd_size(MAX_SIDE, SIDE_W),
                      rnd_pad(), rnd_pad(), rnd_pad(), MODE_UNDEF);
        default: set_config(rnd_size(MAX_CHANNELS, NC_W), rnd_size(MAX_FRAMES, NF_W),
                            rnd_size(MAX_SIDE, SIDE_W), rnd_size(MAX_SIDE, SIDE_W),
                            rnd_pad(), rnd_pad(), rnd_pad(),
                            MODE_W'($urandom_range(0, 3)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) pending_q.push_back(gen_coord());
      // Stall the output long enough to back the pipeline up into the input
      if (p == 1 || p == 6) hold_tgl = ~hold_tgl;
      drain();
    end

    $display("Sent %0d coordinate words over %0d register settings, all four modes.",
             n_items, n_settings);
    $display("Checked %0d results: %0d zero-fill, %0d out of range, %0d mismatches.",
             n_checked, n_zero, n_range, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
